### rtl/core/sha1_message_hash_macros.svh
// Assertion macros for the SHA-1 message hash block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SHA1_MESSAGE_HASH_MACROS_SVH
`define SHA1_MESSAGE_HASH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SHA1MH_ASSERT_IMPLY(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHA1MH_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sha1mh_pkg.sv
// Shared types and constants for the SHA-1 message hash block.
// No dependencies; used by the controller, the datapath and the top level.
package sha1mh_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int FILL_W      = 6;
    localparam int COUNT_W     = 61;
    localparam int ROUND_W     = 7;
    localparam int INDEX_W     = 3;

    localparam logic [WORD_W-1:0] H0 = 32'h67452301;
    localparam logic [WORD_W-1:0] H1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H3 = 32'h10325476;
    localparam logic [WORD_W-1:0] H4 = 32'hC3D2E1F0;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_PHASE1 = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_PHASE2 = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PHASE3 = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd4;

    localparam logic [7:0]        PAD_MARK_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] FILL_LEN_START = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST     = 6'd63;

    typedef enum logic [1:0] {
        BYTE_IN   = 2'd0,
        BYTE_MARK = 2'd1,
        BYTE_ZERO = 2'd2,
        BYTE_LEN  = 2'd3
    } byte_sel_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MARK  = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic               put_byte;
        byte_sel_t          byte_sel;
        logic               count_inc;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               final_add;
        logic               out_load;
        logic               restart;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_len_start;
        logic fill_zero;
    } dp_sts_t;

    function automatic logic [WORD_W-1:0] init_word(input logic [INDEX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            3'd0:    w = H0;
            3'd1:    w = H1;
            3'd2:    w = H2;
            3'd3:    w = H3;
            default: w = H4;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/sha1_message_hash.sv
// SHA-1 message hash, one byte per item. Items are taken while the block is
// idle. The byte that completes a 64-byte block starts a compression: 80
// rounds at one per cycle in the round unit, then a final step folding the
// result into the chaining value, with input held off meanwhile. End of
// message feeds padding and the length one byte per cycle, pausing between
// the zeros and the length and for each of the one or two compressions, then
// loads the five digest words into the output register, one per cycle as the
// sink takes them, and returns to the initial hash.
// Depends on sha1mh_pkg, sha1mh_ctrl, sha1mh_datapath and the macro header.
`include "sha1_message_hash_macros.svh"

module sha1_message_hash (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              byte_present,
    input  logic                              end_of_message,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sha1mh_pkg::WORD_W-1:0]     digest_word,
    output logic [sha1mh_pkg::INDEX_W-1:0]    word_index,
    output logic                              last_word
);
    import sha1mh_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    sha1mh_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .cmd            (cmd),
        .sts            (sts)
    );

    sha1mh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .sts         (sts),
        .digest_word (digest_word)
    );

    // a closing item always starts padding, so the input side goes busy
    `SHA1MH_ASSERT_NEXT(a_end_goes_busy, in_valid && in_ready && end_of_message,
        !in_ready, "end of message did not stall input")
    // a compression only starts right after the block filled
    `SHA1MH_ASSERT_IMPLY(a_round_fill_wrapped, cmd.round_en, sts.fill_zero,
        "round running with a partial block")
    `SHA1MH_ASSERT_IMPLY(a_last_word_index, out_valid && last_word,
        word_index == LAST_INDEX, "last word flag on wrong index")

endmodule

### rtl/core/sha1mh_datapath.sv
// Datapath: block/schedule window, round unit, chaining value, byte count,
// digest output register. Depends on sha1mh_pkg.
module sha1mh_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sha1mh_pkg::dp_cmd_t               cmd,
    input  logic [7:0]                        data_byte,
    output sha1mh_pkg::dp_sts_t               sts,
    output logic [sha1mh_pkg::WORD_W-1:0]     digest_word
);
    import sha1mh_pkg::*;

    // win_reg[0] is the oldest word; bytes enter at the low end of word 15.
    logic [WORD_W-1:0]  win_reg   [BLOCK_WORDS];
    logic [WORD_W-1:0]  win_next  [BLOCK_WORDS];
    logic [WORD_W-1:0]  chain_reg [NUM_WORDS];
    logic [WORD_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [WORD_W-1:0]  digest_reg;

    logic [7:0]         byte_val;
    logic [7:0]         len_byte;
    logic [63:0]        bit_len;
    logic [2:0]         len_sel;
    logic [WORD_W-1:0]  sched_mix;
    logic [WORD_W-1:0]  sched_word;
    logic [WORD_W-1:0]  wt;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  k_val;
    logic [WORD_W-1:0]  tmp;
    logic               early_round;

    assign bit_len = {count_reg, 3'b000};
    assign len_sel = ~fill_reg[2:0];
    assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

    always_comb
    begin
        case (cmd.byte_sel)
            BYTE_IN:   byte_val = data_byte;
            BYTE_MARK: byte_val = PAD_MARK_BYTE;
            BYTE_ZERO: byte_val = 8'h00;
            BYTE_LEN:  byte_val = len_byte;
            default:   byte_val = 8'h00;
        endcase
    end

    assign early_round = (cmd.round < ROUND_SCHED);
    assign sched_mix   = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign sched_word  = {sched_mix[WORD_W-2:0], sched_mix[WORD_W-1]};
    assign wt          = early_round ? win_reg[0] : sched_word;

    always_comb
    begin
        if (cmd.round < ROUND_PHASE1)
        begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K0;
        end
        else if (cmd.round < ROUND_PHASE2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (cmd.round < ROUND_PHASE3)
        begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + wt;

    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (cmd.put_byte)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[BLOCK_WORDS-1] = {win_reg[BLOCK_WORDS-1][23:0], byte_val};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[BLOCK_WORDS-1] = wt;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        // Working variables track the chaining value whenever no round runs.
        if (cmd.round_en)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        if (cmd.out_load)
        begin
            digest_reg <= chain_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_reg[i] <= init_word(INDEX_W'(i));
            end
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_reg[i] <= init_word(INDEX_W'(i));
                end
                fill_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.final_add)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                end
                else if (cmd.out_load)
                begin
                    // rotate so the next digest word sits in slot 0
                    for (int i = 0; i < NUM_WORDS - 1; i++)
                    begin
                        chain_reg[i] <= chain_reg[i+1];
                    end
                    chain_reg[NUM_WORDS-1] <= chain_reg[0];
                end
                if (cmd.put_byte)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (cmd.count_inc)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign sts.fill_last      = (fill_reg == FILL_LAST);
    assign sts.fill_len_start = (fill_reg == FILL_LEN_START);
    assign sts.fill_zero      = (fill_reg == '0);
    assign digest_word        = digest_reg;

endmodule

### rtl/core/sha1mh_ctrl.sv
// Controller state machine: input acceptance, padding sequence, round
// counter and digest emission. Depends on sha1mh_pkg.
module sha1mh_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              byte_present,
    input  logic                              end_of_message,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sha1mh_pkg::INDEX_W-1:0]    word_index,
    output logic                              last_word,
    output sha1mh_pkg::dp_cmd_t               cmd,
    input  sha1mh_pkg::dp_sts_t               sts
);
    import sha1mh_pkg::*;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] word_index_reg, word_index_next;
    logic               last_word_reg, last_word_next;
    logic               load_ok;

    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        word_index_next = word_index_reg;
        last_word_next  = last_word_reg;
        cmd             = '0;
        cmd.byte_sel    = BYTE_IN;
        cmd.round       = round_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.put_byte  = 1'b1;
                        cmd.count_inc = 1'b1;
                    end
                    if (byte_present && sts.fill_last)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = end_of_message ? ST_MARK : ST_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.put_byte = 1'b1;
                cmd.byte_sel = BYTE_MARK;
                if (sts.fill_last)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (sts.fill_len_start)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.put_byte = 1'b1;
                    cmd.byte_sel = BYTE_ZERO;
                    if (sts.fill_last)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = ST_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.put_byte = 1'b1;
                cmd.byte_sel = BYTE_LEN;
                if (sts.fill_last)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = ST_FINAL;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    cmd.out_load    = 1'b1;
                    word_index_next = idx_reg;
                    last_word_next  = (idx_reg == LAST_INDEX);
                    if (idx_reg == LAST_INDEX)
                    begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_index_reg <= word_index_next;
        last_word_reg  <= last_word_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign word_index = word_index_reg;
    assign last_word  = last_word_reg;

endmodule

### bench/sha1_message_hash_checker.sv
// Checker for the SHA-1 message hash block: watches both channels, hashes the
// accepted bytes itself and compares every digest word the block returns.
// Depends on sha1mh_pkg for widths and the SHA-1 constants.
module sha1_message_hash_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           byte_present,
    input  logic                           end_of_message,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [sha1mh_pkg::WORD_W-1:0]  digest_word,
    input  logic [sha1mh_pkg::INDEX_W-1:0] word_index,
    input  logic                           last_word,
    output int                             failures,
    output int                             words_due,
    output int                             words_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import sha1mh_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] idx;
        logic               last;
    } digest_entry_t;

    digest_entry_t digest_queue[$];

    logic [WORD_W-1:0]  hash_state [NUM_WORDS];
    logic [WORD_W-1:0]  msg_block [BLOCK_WORDS];
    logic [FILL_W-1:0]  block_fill;
    logic [COUNT_W-1:0] msg_len_bytes;

    initial
    begin
        failures = 0;
        words_due = 0;
        words_checked = 0;
    end

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic void restart_hash();
        hash_state[0] = H0;
        hash_state[1] = H1;
        hash_state[2] = H2;
        hash_state[3] = H3;
        hash_state[4] = H4;
        block_fill = '0;
        msg_len_bytes = '0;
    endfunction

    function automatic void compress_block();
        logic [WORD_W-1:0] w [BLOCK_WORDS];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, wt, sum;
        w = msg_block;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wt = w[r];
            else
            begin
                // rolling 16-word schedule window
                wt = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
                w[r % 16] = wt;
            end
            if (r < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (d & (b | c));
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            sum = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // big-endian packing; the byte at position 63 completes the block
    function automatic void pack_byte(input logic [7:0] v);
        msg_block[block_fill[5:2]][(3 - block_fill[1:0]) * 8 +: 8] = v;
        if (block_fill == FILL_LAST)
            compress_block();
        block_fill = block_fill + 1'b1;
    endfunction

    function automatic void finish_message();
        logic [63:0] bit_len;
        digest_entry_t entry;
        bit_len = {msg_len_bytes, 3'b000};
        pack_byte(PAD_MARK_BYTE);
        while (block_fill != FILL_LEN_START)
            pack_byte(8'h00);
        for (int i = 7; i >= 0; i--)
            pack_byte(bit_len[i * 8 +: 8]);
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            entry.word = hash_state[i];
            entry.idx = INDEX_W'(i);
            entry.last = (entry.idx == LAST_INDEX);
            digest_queue.push_back(entry);
        end
        restart_hash();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        failures++;
    endtask

    always @(posedge clk)
    begin
        digest_entry_t want;
        if (!rst_n)
        begin
            restart_hash();
            digest_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (byte_present)
                begin
                    pack_byte(data_byte);
                    msg_len_bytes = msg_len_bytes + 1'b1;
                end
                if (end_of_message)
                    finish_message();
            end
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                    report_mismatch($sformatf("unexpected digest word %08h", digest_word));
                else
                begin
                    want = digest_queue.pop_front();
                    words_checked++;
                    if (digest_word !== want.word)
                        report_mismatch($sformatf("word %0d is %08h, want %08h",
                                                  want.idx, digest_word, want.word));
                    if (word_index !== want.idx)
                        report_mismatch($sformatf("word_index is %0d, want %0d",
                                                  word_index, want.idx));
                    if (last_word !== want.last)
                        report_mismatch($sformatf("last_word is %b on word %0d",
                                                  last_word, want.idx));
                end
            end
        end
        words_due = digest_queue.size();
    end

endmodule

### bench/sha1_message_hash_test.sv
// Top of the SHA-1 message hash bench: clock, reset, byte stimulus and the
// receiver's stalls; the checker module does all prediction and comparison.
// Depends on sha1mh_pkg, sha1_message_hash and sha1_message_hash_checker.
module sha1_message_hash_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sha1mh_pkg::*;

    localparam int ITEM_TARGET = 350;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               byte_present;
    logic               end_of_message;
    logic               out_valid;
    logic               out_ready;
    logic [WORD_W-1:0]  digest_word;
    logic [INDEX_W-1:0] word_index;
    logic               last_word;

    int failures;
    int words_due;
    int words_checked;
    int items_sent;
    int messages_sent;
    int bytes_sent;
    int longest_msg;
    int msg_len;
    bit quiet;
    bit hold_go;
    bit hold_taken;

    // lengths around the padding and block boundaries
    int pad_lengths[8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    sha1_message_hash dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sha1_message_hash_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .failures       (failures),
        .words_due      (words_due),
        .words_checked  (words_checked)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic offer(input logic [7:0] value, input logic present, input logic closes);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        byte_present <= present;
        end_of_message <= closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (present || closes)
            items_sent++;
    endtask

    // split_end closes with a separate item that carries no byte
    task automatic send_message(input int len, input bit split_end, input bit noisy);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_end);
        end
        if (len == 0 || split_end)
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_sent++;
        bytes_sent += len;
        if (len > longest_msg)
            longest_msg = len;
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_taken = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        quiet = 1'b0;
        hold_go = 1'b0;
        items_sent = 0;
        messages_sent = 0;
        bytes_sent = 0;
        longest_msg = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then an item that carries nothing
        offer(8'h3C, 1'b0, 1'b1);
        offer(8'hFF, 1'b0, 1'b0);
        // "abc", closed on its last byte
        offer(8'h61, 1'b1, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b1);
        // extreme bytes, closed by an item with no byte
        offer(8'h00, 1'b1, 1'b0);
        offer(8'h00, 1'b0, 1'b0);
        offer(8'hFF, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        offer(8'h00, 1'b1, 1'b1);
        messages_sent += 5;
        bytes_sent += 7;
        longest_msg = 3;

        // receiver stops for a while; short messages pile up behind it
        hold_go = 1'b1;
        repeat (8) send_message($urandom_range(0, 3), $urandom_range(0, 1), 1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET * 3 / 4)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                msg_len = pad_lengths[$urandom_range(0, 7)];
            else
                msg_len = $urandom_range(0, 20);
            send_message(msg_len, $urandom_range(0, 1), 1'b1);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Hashed %0d messages (%0d bytes, longest %0d) over %0d items,",
                 messages_sent, bytes_sent, longest_msg, items_sent);
        $display("incl. empty, split-end and pad-boundary lengths; %0d digest words checked.",
                 words_checked);
        if (words_due != 0)
            $display("%0d digest words never arrived", words_due);
        if (failures == 0 && words_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("timeout: block stopped making progress");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
